/* hdl/csi_c2p_pkg.sv */
// Package for the channel-sample Cartesian-to-polar converter.
// Holds fixed-point constants, the sample flag type and the arctangent table.
// No dependencies.
package csi_c2p_pkg;

  // Fraction bits of the x and y datapath, and bits added to the sample width (fraction plus headroom).
  localparam int FRAC_BITS = 16;
  localparam int XY_GUARD  = 18;

  // Angle accumulator width (Q.20 radians) and the widened phase sum.
  localparam int ANGLE_W = 22;
  localparam int PSUM_W  = 24;

  // Result field widths.
  localparam int MAG_W   = 12;
  localparam int PHASE_W = 15;

  // Constants of the fixed-point formats.
  localparam int          GAIN_W     = 16;
  localparam logic [15:0] INV_GAIN   = 16'd39797;
  localparam int          MAG_SHIFT  = 28;
  localparam int          PH_SHIFT   = 8;
  localparam int          PI_Q20     = 3294199;
  localparam int          PI_Q12     = 12868;

  // Per-sample flags carried alongside the datapath.
  typedef struct packed {
    logic im_zero;
    logic re_neg;
    logic im_neg;
  } c2p_flags_t;

  // Arctangent of 2^-idx in Q.20 radians, rounded to nearest.
  function automatic logic [19:0] atan_q20(input int unsigned idx);
    logic [19:0] v;
    begin
      case (idx)
        0:       v = 20'd823550;
        1:       v = 20'd486170;
        2:       v = 20'd256879;
        3:       v = 20'd130396;
        4:       v = 20'd65451;
        5:       v = 20'd32757;
        6:       v = 20'd16383;
        7:       v = 20'd8192;
        8:       v = 20'd4096;
        9:       v = 20'd2048;
        10:      v = 20'd1024;
        11:      v = 20'd512;
        12:      v = 20'd256;
        13:      v = 20'd128;
        14:      v = 20'd64;
        15:      v = 20'd32;
        16:      v = 20'd16;
        17:      v = 20'd8;
        18:      v = 20'd4;
        19:      v = 20'd2;
        20:      v = 20'd1;
        default: v = 20'd0;
      endcase
      return v;
    end
  endfunction

endpackage

/* hdl/csi_cartesian_to_polar_unit.sv */
// Channel-sample Cartesian-to-polar converter: CORDIC vectoring chain.
// Channels: in_* takes one sample word (real, imaginary) per handshake;
// out_* gives magnitude (unsigned, 4 fraction bits) and phase (radians,
// 12 fraction bits); cfg_* writes the capture enable bit.
// While capture is disabled, input words are accepted and dropped.
// From acceptance to the result handshake a word passes one folding
// cell, one cell per micro-rotation, a gain multiply stage and the
// result register. Throughput is one word per cycle while the receiver
// does not stall; every cell holds one word in flight.
// Each cell is ready when empty or when its word moves on, so bubbles
// close up while the receiver stalls and input is refused only once the
// whole chain is full.
// Reset (rst_n low, synchronous) empties the chain and disables capture.
// Depends on csi_c2p_pkg, csi_c2p_prerot, csi_c2p_cell and csi_c2p_post.
module csi_cartesian_to_polar_unit import csi_c2p_pkg::*; #(
  parameter int SAMPLE_BITS   = 8,
  parameter int CORDIC_STAGES = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_capture_enable,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_real_part,
  input  logic signed [SAMPLE_BITS-1:0] in_imag_part,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [MAG_W-1:0]       out_magnitude,
  output logic signed [PHASE_W-1:0]     out_phase
);

  localparam int W = SAMPLE_BITS + XY_GUARD;

  logic capture_enable_r, capture_enable_nxt;
  logic pre_in_ready;

  // Chain links: index 0 is the folding cell's output.
  logic                      v_a      [CORDIC_STAGES+1];
  logic                      r_a      [CORDIC_STAGES+1];
  logic signed [W-1:0]       x_a      [CORDIC_STAGES+1];
  logic signed [W-1:0]       y_a      [CORDIC_STAGES+1];
  logic signed [ANGLE_W-1:0] z_a      [CORDIC_STAGES+1];
  c2p_flags_t                f_a      [CORDIC_STAGES+1];
  logic [SAMPLE_BITS-1:0]    abs_a    [CORDIC_STAGES+1];

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_comb begin
    capture_enable_nxt = capture_enable_r;
    if (cfg_valid && cfg_ready) begin
      capture_enable_nxt = cfg_capture_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_enable_r <= 1'b0;
    end else begin
      capture_enable_r <= capture_enable_nxt;
    end
  end

  // Words are swallowed while capture is off.
  assign in_ready = capture_enable_r ? pre_in_ready : 1'b1;

  csi_c2p_prerot #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_prerot (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid && capture_enable_r),
    .in_ready   (pre_in_ready),
    .in_re      (in_real_part),
    .in_im      (in_imag_part),
    .out_valid  (v_a[0]),
    .out_ready  (r_a[0]),
    .out_x      (x_a[0]),
    .out_y      (y_a[0]),
    .out_flags  (f_a[0]),
    .out_abs_re (abs_a[0])
  );

  assign z_a[0] = '0;

  // Micro-rotation chain.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    csi_c2p_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .STAGE      (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .in_valid   (v_a[i]),
      .in_ready   (r_a[i]),
      .in_x       (x_a[i]),
      .in_y       (y_a[i]),
      .in_z       (z_a[i]),
      .in_flags   (f_a[i]),
      .in_abs_re  (abs_a[i]),
      .out_valid  (v_a[i+1]),
      .out_ready  (r_a[i+1]),
      .out_x      (x_a[i+1]),
      .out_y      (y_a[i+1]),
      .out_z      (z_a[i+1]),
      .out_flags  (f_a[i+1]),
      .out_abs_re (abs_a[i+1])
    );
  end

  csi_c2p_post #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (v_a[CORDIC_STAGES]),
    .in_ready      (r_a[CORDIC_STAGES]),
    .in_x          (x_a[CORDIC_STAGES]),
    .in_z          (z_a[CORDIC_STAGES]),
    .in_flags      (f_a[CORDIC_STAGES]),
    .in_abs_re     (abs_a[CORDIC_STAGES]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_magnitude (out_magnitude),
    .out_phase     (out_phase)
  );

  // The last link's y is not used by the output end.
  logic unused_y;
  assign unused_y = ^y_a[CORDIC_STAGES];

endmodule

/* hdl/csi_c2p_prerot.sv */
// Input cell: sign-extends the sample, folds the left half plane onto the
// right one and scales to the Q.16 datapath. Depends on csi_c2p_pkg.
module csi_c2p_prerot import csi_c2p_pkg::*; #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic signed [SAMPLE_BITS-1:0]                in_re,
  input  logic signed [SAMPLE_BITS-1:0]                in_im,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic signed [SAMPLE_BITS+XY_GUARD-1:0]       out_x,
  output logic signed [SAMPLE_BITS+XY_GUARD-1:0]       out_y,
  output c2p_flags_t                                   out_flags,
  output logic        [SAMPLE_BITS-1:0]                out_abs_re
);

  localparam int W = SAMPLE_BITS + XY_GUARD;

  logic                   valid_r, valid_nxt;
  logic signed [W-1:0]    x_r, x_nxt;
  logic signed [W-1:0]    y_r, y_nxt;
  c2p_flags_t             flags_r, flags_nxt;
  logic [SAMPLE_BITS-1:0] abs_re_r, abs_re_nxt;
  logic signed [W-1:0]    y_ext;

  // The cell takes a new word when empty or when its word moves on.
  assign in_ready = !valid_r || out_ready;

  // Fold into the right half plane: negate both parts when re is negative.
  always_comb begin
    flags_nxt.re_neg  = in_re[SAMPLE_BITS-1];
    flags_nxt.im_neg  = in_im[SAMPLE_BITS-1];
    flags_nxt.im_zero = (in_im == '0);
    abs_re_nxt = in_re[SAMPLE_BITS-1] ? SAMPLE_BITS'(~in_re + 1'b1) : in_re;
    x_nxt      = W'({1'b0, abs_re_nxt}) <<< FRAC_BITS;
    y_ext      = W'(in_im) <<< FRAC_BITS;
    y_nxt      = in_re[SAMPLE_BITS-1] ? -y_ext : y_ext;
  end

  // Valid bit follows the handshake.
  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      flags_r  <= flags_nxt;
      abs_re_r <= abs_re_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_x      = x_r;
  assign out_y      = y_r;
  assign out_flags  = flags_r;
  assign out_abs_re = abs_re_r;

endmodule

/* hdl/csi_c2p_cell.sv */
// One vectoring micro-rotation cell of the CORDIC chain.
// Rotates toward the x axis by atan(2^-STAGE). Depends on csi_c2p_pkg.
module csi_c2p_cell import csi_c2p_pkg::*; #(
  parameter int SAMPLE_BITS = 8,
  parameter int STAGE       = 0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS+XY_GUARD-1:0] in_x,
  input  logic signed [SAMPLE_BITS+XY_GUARD-1:0] in_y,
  input  logic signed [ANGLE_W-1:0]              in_z,
  input  c2p_flags_t                             in_flags,
  input  logic        [SAMPLE_BITS-1:0]          in_abs_re,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [SAMPLE_BITS+XY_GUARD-1:0] out_x,
  output logic signed [SAMPLE_BITS+XY_GUARD-1:0] out_y,
  output logic signed [ANGLE_W-1:0]              out_z,
  output c2p_flags_t                             out_flags,
  output logic        [SAMPLE_BITS-1:0]          out_abs_re
);

  localparam int W = SAMPLE_BITS + XY_GUARD;
  localparam logic signed [ANGLE_W-1:0] STEP = ANGLE_W'(atan_q20(STAGE));

  logic                      valid_r, valid_nxt;
  logic signed [W-1:0]       x_r, x_nxt;
  logic signed [W-1:0]       y_r, y_nxt;
  logic signed [ANGLE_W-1:0] z_r, z_nxt;
  c2p_flags_t                flags_r;
  logic [SAMPLE_BITS-1:0]    abs_re_r;
  logic signed [W-1:0]       xs, ys;

  assign in_ready = !valid_r || out_ready;

  // Micro-rotation: the sign of y picks the direction.
  always_comb begin
    xs = in_x >>> STAGE;
    ys = in_y >>> STAGE;
    if (!in_y[W-1]) begin
      x_nxt = in_x + ys;
      y_nxt = in_y - xs;
      z_nxt = in_z + STEP;
    end else begin
      x_nxt = in_x - ys;
      y_nxt = in_y + xs;
      z_nxt = in_z - STEP;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      z_r      <= z_nxt;
      flags_r  <= in_flags;
      abs_re_r <= in_abs_re;
    end
  end

  assign out_valid  = valid_r;
  assign out_x      = x_r;
  assign out_y      = y_r;
  assign out_z      = z_r;
  assign out_flags  = flags_r;
  assign out_abs_re = abs_re_r;

endmodule

/* hdl/csi_c2p_post.sv */
// Output end: gain compensation, rounding, saturation and the result register.
// Two register stages. Depends on csi_c2p_pkg.
module csi_c2p_post import csi_c2p_pkg::*; #(
  parameter int SAMPLE_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_BITS+XY_GUARD-1:0] in_x,
  input  logic signed [ANGLE_W-1:0]              in_z,
  input  c2p_flags_t                             in_flags,
  input  logic        [SAMPLE_BITS-1:0]          in_abs_re,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic        [MAG_W-1:0]                out_magnitude,
  output logic signed [PHASE_W-1:0]              out_phase
);

  localparam int W   = SAMPLE_BITS + XY_GUARD;
  localparam int PW  = W - 1 + GAIN_W;
  localparam int QW  = PW + 1 - MAG_SHIFT;
  localparam int BW  = SAMPLE_BITS + 4;
  localparam int RW  = PSUM_W - PH_SHIFT;

  // Stage A registers: product and phase sum.
  logic                     va_r, va_nxt;
  logic [PW-1:0]            prod_r;
  logic signed [PSUM_W-1:0] psum_r, psum_nxt;
  c2p_flags_t               flags_r;
  logic [SAMPLE_BITS-1:0]   abs_re_r;
  logic                     a_ready;

  // Stage B: the result register.
  logic                     vb_r, vb_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic signed [PHASE_W-1:0] ph_r, ph_nxt;

  logic [PW:0]              prod_rnd;
  logic [QW+MAG_W-1:0]      q_ext;
  logic [BW+MAG_W-1:0]      b_ext;
  logic signed [PSUM_W-1:0] psum_rnd;
  logic signed [RW-1:0]     ph_sh;
  logic signed [PSUM_W-1:0] base;

  assign a_ready  = !vb_r || out_ready;
  assign in_ready = !va_r || a_ready;

  // Pi offset for samples folded from the left half plane.
  always_comb begin
    base = '0;
    if (in_flags.re_neg) begin
      base = in_flags.im_neg ? -PSUM_W'(PI_Q20) : PSUM_W'(PI_Q20);
    end
    psum_nxt = PSUM_W'(in_z) + base;
  end

  always_comb begin
    va_nxt = va_r;
    if (in_ready) begin
      va_nxt = in_valid;
    end
    vb_nxt = vb_r;
    if (a_ready) begin
      vb_nxt = va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  // Gain compensation multiply; x is never negative here.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_r   <= PW'(in_x[W-2:0]) * PW'(INV_GAIN);
      psum_r   <= psum_nxt;
      flags_r  <= in_flags;
      abs_re_r <= in_abs_re;
    end
  end

  // Round half up, shift down and saturate both results.
  always_comb begin
    prod_rnd = {1'b0, prod_r} + (PW + 1)'(1 << (MAG_SHIFT - 1));
    q_ext    = (QW + MAG_W)'(prod_rnd[PW:MAG_SHIFT]);
    b_ext    = (BW + MAG_W)'({abs_re_r, 4'b0000});
    psum_rnd = psum_r + PSUM_W'(1 << (PH_SHIFT - 1));
    ph_sh    = psum_rnd[PSUM_W-1:PH_SHIFT];
    if (flags_r.im_zero) begin
      mag_nxt = (|b_ext[BW+MAG_W-1:MAG_W]) ? '1 : b_ext[MAG_W-1:0];
      ph_nxt  = flags_r.re_neg ? PHASE_W'(PI_Q12) : '0;
    end else begin
      mag_nxt = (|q_ext[QW+MAG_W-1:MAG_W]) ? '1 : q_ext[MAG_W-1:0];
      if (ph_sh > RW'(PI_Q12)) begin
        ph_nxt = PHASE_W'(PI_Q12);
      end else if (ph_sh < -RW'(PI_Q12)) begin
        ph_nxt = -PHASE_W'(PI_Q12);
      end else begin
        ph_nxt = ph_sh[PHASE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (va_r && a_ready) begin
      mag_r <= mag_nxt;
      ph_r  <= ph_nxt;
    end
  end

  assign out_valid     = vb_r;
  assign out_magnitude = mag_r;
  assign out_phase     = ph_r;

endmodule

/* hdl/csi_c2p_checker.sv */
// Port-level checker for csi_cartesian_to_polar_unit, attached by bind.
// Depends on csi_c2p_pkg.
module csi_c2p_checker import csi_c2p_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic        [MAG_W-1:0]   out_magnitude,
  input logic signed [PHASE_W-1:0] out_phase
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // The phase never leaves the range -pi to +pi.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase <= PHASE_W'(PI_Q12)) && (out_phase >= -PHASE_W'(PI_Q12)))
    else $error("phase out of range");

  // Reset empties the chain: no result right after it.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word right after reset");

  // Register writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind csi_cartesian_to_polar_unit csi_c2p_checker u_csi_c2p_checker (.*);
